// ===== hw/rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  // widest operand magnitude carried between front and back
  localparam int MAG_W = 32;

  typedef enum logic [2:0] {
    MODE_REDUCE = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_SUB    = 3'd2,
    MODE_MUL    = 3'd3,
    MODE_DIV    = 3'd4,
    MODE_CMP    = 3'd5,
    MODE_INC    = 3'd6,
    MODE_DEC    = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD_EVEN,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Classified request: three sign/magnitude products.
  // num = (s0,x0*y0) +/- (s1,x1*y1), den = (s2,x2*y2)
  typedef struct packed {
    logic [MAG_W-1:0] x0;
    logic [MAG_W-1:0] y0;
    logic [MAG_W-1:0] x1;
    logic [MAG_W-1:0] y1;
    logic [MAG_W-1:0] x2;
    logic [MAG_W-1:0] y2;
    logic             s0;
    logic             s1;
    logic             s2;
    logic             sub;
    logic             cmp;
    logic             err;
  } op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rau_if.sv =====
`default_nettype none
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        is_less;
  logic        is_equal;
  logic        div_error;
  logic        overflow;

  modport source (output valid, res_num, res_den, is_less, is_equal, div_error, overflow,
                  input ready);
  modport sink (input valid, res_num, res_den, is_less, is_equal, div_error, overflow,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rau_front.sv =====
`default_nettype none
module rau_front import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  rau_req_if.sink   req,
  output logic      f_valid,
  input  wire logic f_ready,
  output op_t       f_op
);
  localparam int W = OPERAND_WIDTH;

  logic [W-1:0] am, adm, bm, bdm;
  logic         as, ads, bs, bds;
  logic         uses_b;
  op_t          op_next;
  mode_t        mode;

  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    logic [W-1:0] f;
    f = v[W-1:0];
    return f[W-1] ? (~f + W'(1)) : f;
  endfunction

  assign am  = mag_of(req.a_num);
  assign adm = mag_of(req.a_den);
  assign bm  = mag_of(req.b_num);
  assign bdm = mag_of(req.b_den);
  assign as  = req.a_num[W-1];
  assign ads = req.a_den[W-1];
  assign bs  = req.b_num[W-1];
  assign bds = req.b_den[W-1];
  assign mode = mode_t'(req.mode);
  assign uses_b = mode inside {[MODE_ADD:MODE_CMP]};

  always_comb begin
    op_next = '0;
    op_next.err = (adm == '0) || (uses_b && bdm == '0) || (mode == MODE_DIV && bm == '0);
    case (mode)
      MODE_REDUCE: begin
        op_next.x0 = MAG_W'(am);  op_next.y0 = MAG_W'(1); op_next.s0 = as;
        op_next.x2 = MAG_W'(adm); op_next.y2 = MAG_W'(1); op_next.s2 = ads;
      end
      MODE_ADD, MODE_SUB: begin
        op_next.x0 = MAG_W'(am);  op_next.y0 = MAG_W'(bdm); op_next.s0 = as ^ bds;
        op_next.x1 = MAG_W'(bm);  op_next.y1 = MAG_W'(adm); op_next.s1 = bs ^ ads;
        op_next.x2 = MAG_W'(adm); op_next.y2 = MAG_W'(bdm); op_next.s2 = ads ^ bds;
        op_next.sub = (mode == MODE_SUB);
      end
      MODE_MUL: begin
        op_next.x0 = MAG_W'(am);  op_next.y0 = MAG_W'(bm);  op_next.s0 = as ^ bs;
        op_next.x2 = MAG_W'(adm); op_next.y2 = MAG_W'(bdm); op_next.s2 = ads ^ bds;
      end
      MODE_DIV: begin
        op_next.x0 = MAG_W'(am);  op_next.y0 = MAG_W'(bdm); op_next.s0 = as ^ bds;
        op_next.x2 = MAG_W'(adm); op_next.y2 = MAG_W'(bm);  op_next.s2 = ads ^ bs;
      end
      MODE_CMP: begin
        // denominator signs folded into the numerators
        op_next.x0 = MAG_W'(am); op_next.y0 = MAG_W'(bdm); op_next.s0 = as ^ ads;
        op_next.x1 = MAG_W'(bm); op_next.y1 = MAG_W'(adm); op_next.s1 = bs ^ bds;
        op_next.x2 = MAG_W'(1);  op_next.y2 = MAG_W'(1);
        op_next.sub = 1'b1;
        op_next.cmp = 1'b1;
      end
      MODE_INC, MODE_DEC: begin
        op_next.x0 = MAG_W'(am);  op_next.y0 = MAG_W'(1); op_next.s0 = as;
        op_next.x1 = MAG_W'(adm); op_next.y1 = MAG_W'(1); op_next.s1 = ads;
        op_next.x2 = MAG_W'(adm); op_next.y2 = MAG_W'(1); op_next.s2 = ads;
        op_next.sub = (mode == MODE_DEC);
      end
      default: op_next = '0;
    endcase
  end

  assign req.ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (req.ready) begin
      f_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      f_op <= op_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rau_queue.sv =====
`default_nettype none
module rau_queue import rau_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire op_t  wr_op,
  output logic      rd_valid,
  input  wire logic rd_pop,
  output op_t       rd_op
);
  // two-entry queue
  op_t        mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign rd_op    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (rd_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(rd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_op;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rau_back.sv =====
`default_nettype none
module rau_back import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_pop,
  input  wire op_t  q_op,
  rau_rsp_if.source rsp
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW-1:0] LIM = PW'((64'd1 << (W - 1)) - 64'd1);

  state_t        state, state_next;
  op_t           op;
  logic [1:0]    mcnt;
  logic [PW-1:0] p0, p1, pd;
  logic [PW-1:0] nmag, dmag, u, v, g, rem, quo;
  logic          nneg;
  logic [CW-1:0] k, cnt;
  logic [31:0]   w_num;
  logic [30:0]   w_den;
  logic          w_less, w_eq, w_err, w_ovf;

  logic [W-1:0]  xs, ys;
  logic [PW-1:0] prod;
  logic          t1neg, sneg, szero;
  logic [PW-1:0] smag, gsub, quo_step;
  logic [PW:0]   remsh;
  logic          ge;
  logic [W-1:0]  num_w;
  logic          out_load;

  // shared multiplier: one product per cycle
  always_comb begin
    case (mcnt)
      2'd0:    begin xs = op.x0[W-1:0]; ys = op.y0[W-1:0]; end
      2'd1:    begin xs = op.x1[W-1:0]; ys = op.y1[W-1:0]; end
      default: begin xs = op.x2[W-1:0]; ys = op.y2[W-1:0]; end
    endcase
  end
  assign prod = PW'(xs) * PW'(ys);

  // sign/magnitude sum of the two numerator terms
  always_comb begin
    t1neg = op.s1 ^ op.sub;
    if (op.s0 == t1neg) begin
      smag = p0 + p1;
      sneg = op.s0;
    end else if (p0 >= p1) begin
      smag = p0 - p1;
      sneg = op.s0;
    end else begin
      smag = p1 - p0;
      sneg = t1neg;
    end
    szero = (smag == '0);
  end

  assign gsub     = (u >= v) ? (u - v) : (v - u);
  assign remsh    = {rem, quo[PW-1]};
  assign ge       = (remsh >= {1'b0, g});
  assign quo_step = {quo[PW-2:0], ge};
  assign num_w    = nneg ? (~nmag[W-1:0] + W'(1)) : nmag[W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_valid) state_next = q_op.err ? ST_DONE : ST_MUL;
      ST_MUL:      if (mcnt == 2'd2) state_next = ST_SUM;
      ST_SUM:      state_next = (op.cmp || szero) ? ST_DONE : ST_GCD_EVEN;
      ST_GCD_EVEN: if (u[0] || v[0]) state_next = ST_GCD;
      ST_GCD:      if (u == '0 || v == '0) state_next = ST_DIV_N;
      ST_DIV_N:    if (cnt == CW'(PW - 1)) state_next = ST_DIV_D;
      ST_DIV_D:    if (cnt == CW'(PW - 1)) state_next = ST_CHECK;
      ST_CHECK:    state_next = ST_DONE;
      ST_DONE:     if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state == ST_IDLE) && q_valid;
    out_load = (state == ST_DONE) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op     <= q_op;
        mcnt   <= 2'd0;
        w_num  <= '0;
        w_den  <= 31'd1;
        w_less <= 1'b0;
        w_eq   <= 1'b0;
        w_err  <= q_op.err;
        w_ovf  <= 1'b0;
      end
      ST_MUL: begin
        case (mcnt)
          2'd0:    p0 <= prod;
          2'd1:    p1 <= prod;
          default: pd <= prod;
        endcase
        mcnt <= mcnt + 2'd1;
      end
      ST_SUM: begin
        if (op.cmp) begin
          w_less <= sneg && !szero;
          w_eq   <= szero;
        end
        nmag <= smag;
        dmag <= pd;
        nneg <= !szero && (sneg ^ op.s2);
        u    <= smag;
        v    <= pd;
        k    <= '0;
      end
      ST_GCD_EVEN: begin
        if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + CW'(1);
        end
      end
      ST_GCD: begin
        if (u == '0) begin
          g <= v << k;
        end else if (v == '0) begin
          g <= u << k;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= gsub >> 1;
        end else begin
          v <= gsub >> 1;
        end
        rem <= '0;
        quo <= nmag;
        cnt <= '0;
      end
      ST_DIV_N, ST_DIV_D: begin
        if (cnt == CW'(PW - 1) && state == ST_DIV_N) begin
          // numerator done, start on the denominator
          nmag <= quo_step;
          rem  <= '0;
          quo  <= dmag;
          cnt  <= '0;
        end else begin
          rem <= ge ? PW'(remsh - {1'b0, g}) : remsh[PW-1:0];
          quo <= quo_step;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(PW - 1)) begin
            dmag <= quo_step;
          end
        end
      end
      ST_CHECK: begin
        if (nmag > LIM || dmag > LIM) begin
          w_ovf <= 1'b1;
        end else begin
          w_num <= 32'(signed'(num_w));
          w_den <= 31'(dmag[W-2:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.res_num   <= w_num;
      rsp.res_den   <= w_den;
      rsp.is_less   <= w_less;
      rsp.is_equal  <= w_eq;
      rsp.div_error <= w_err;
      rsp.overflow  <= w_ovf;
    end
  end

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.res_den != '0)
    else $error("result denominator is zero");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.div_error |-> rsp.res_num == '0 && !rsp.overflow && !rsp.is_less)
    else $error("error result carries data");

  a_gcd_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_GCD |-> (u != '0 || v != '0))
    else $error("gcd operands both zero");

  a_div_by_g: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_N |-> g != '0)
    else $error("divide by zero gcd");

endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`default_nettype none
// Rational arithmetic unit.
// req channel: one request carries mode and two fractions a_num/a_den and
//   b_num/b_den (low OPERAND_WIDTH bits used, sign-extended). Modes: reduce,
//   add, sub, mul, div, compare, increment A, decrement A.
// rsp channel: one response per request, in order: reduced res_num/res_den
//   (sign on the numerator), compare flags, div_error and overflow.
// Flow: the front decodes a request into three sign/magnitude products and
//   an error flag, registers it, and pushes it into a two-entry queue. The
//   back pops one request at a time: three products on one shared
//   multiplier, a signed sum, binary gcd (one subtract or shift per
//   cycle), then two restoring divisions by the gcd, a range check
//   and the output register.
// The back takes one request at a time, so its gcd loop and divider
//   limit how fast requests are served.
// Reset clears the valid flags, queue pointers and back state; no clearing
//   pass. A stalled rsp holds the response; the back, queue and front keep
//   taking up to four more requests before req.ready drops.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  logic f_valid, f_ready;
  op_t  f_op;
  logic q_valid, q_pop;
  op_t  q_op;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_op    (f_op)
  );

  rau_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_op    (q_op)
  );

  rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_op    (q_op),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

// ===== tb/rational_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int  WIDTH     = 32;
  localparam int  NUM_RAND  = 850;
  localparam int  LIMIT     = 1500000;
  localparam int  TAIL      = 300;
  localparam logic [63:0] MAG_LIM = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } request_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        is_less;
    logic        is_equal;
    logic        div_error;
    logic        overflow;
  } answer_t;

  // signed value held as sign plus 64-bit magnitude
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } signmag_t;

  logic clk;
  logic rst;

  rau_req_if req ();
  rau_rsp_if rsp ();

  rational_arithmetic_unit #(.OPERAND_WIDTH(WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  request_t pending_q[$];
  answer_t  answer_q[$];
  int       mismatches;
  int       cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic signmag_t sm(logic neg, logic [63:0] mag);
    signmag_t r;
    r.mag = mag;
    r.neg = (mag != 0) ? neg : 1'b0;
    return r;
  endfunction

  // 32-bit field to sign/magnitude; the most negative value keeps 2^31
  function automatic signmag_t operand(logic [31:0] v);
    logic [31:0] m;
    if (v[31]) begin
      m = -v;
      return sm(1'b1, (m == 0) ? 64'h8000_0000 : {32'd0, m});
    end
    return sm(1'b0, {32'd0, v});
  endfunction

  function automatic signmag_t sm_mul(signmag_t a, signmag_t b);
    return sm(a.neg != b.neg, a.mag * b.mag);
  endfunction

  function automatic signmag_t sm_add(signmag_t a, signmag_t b);
    if (a.neg == b.neg) return sm(a.neg, a.mag + b.mag);
    if (a.mag >= b.mag) return sm(a.neg, a.mag - b.mag);
    return sm(b.neg, b.mag - a.mag);
  endfunction

  function automatic signmag_t sm_neg(signmag_t a);
    return sm(!a.neg, a.mag);
  endfunction

  function automatic answer_t reduce_fraction(signmag_t n, signmag_t d);
    answer_t     r;
    logic        neg;
    logic [63:0] nm, dm, x, y, t;
    r = '0;
    r.res_den = 31'd1;
    neg = n.neg != d.neg;
    nm = n.mag;
    dm = d.mag;
    if (nm == 0) begin
      dm = 1;
      neg = 1'b0;
    end else begin
      x = nm;
      y = dm;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = nm / x;
      dm = dm / x;
    end
    if (nm > MAG_LIM || dm > MAG_LIM) begin
      r.overflow = 1'b1;
      return r;
    end
    r.res_num = neg ? -nm[31:0] : nm[31:0];
    r.res_den = dm[30:0];
    return r;
  endfunction

  function automatic answer_t rational_result(request_t q);
    answer_t  r;
    signmag_t an, ad, bn, bd, ln, rn, diff;
    logic     uses_b;
    an = operand(q.a_num);
    ad = operand(q.a_den);
    bn = operand(q.b_num);
    bd = operand(q.b_den);
    r = '0;
    r.res_den = 31'd1;
    uses_b = q.mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP};
    if (ad.mag == 0 || (uses_b && bd.mag == 0) || (q.mode == MODE_DIV && bn.mag == 0)) begin
      r.div_error = 1'b1;
      return r;
    end
    case (mode_t'(q.mode))
      MODE_REDUCE: r = reduce_fraction(an, ad);
      MODE_ADD: r = reduce_fraction(sm_add(sm_mul(an, bd), sm_mul(bn, ad)), sm_mul(ad, bd));
      MODE_SUB: r = reduce_fraction(sm_add(sm_mul(an, bd), sm_neg(sm_mul(bn, ad))),
                                    sm_mul(ad, bd));
      MODE_MUL: r = reduce_fraction(sm_mul(an, bn), sm_mul(ad, bd));
      MODE_DIV: r = reduce_fraction(sm_mul(an, bd), sm_mul(ad, bn));
      MODE_CMP: begin
        // denominator signs go to the numerators before cross-multiplying
        ln = sm(an.neg != ad.neg, an.mag * bd.mag);
        rn = sm(bn.neg != bd.neg, bn.mag * ad.mag);
        diff = sm_add(ln, sm_neg(rn));
        r.is_less = diff.neg && diff.mag != 0;
        r.is_equal = diff.mag == 0;
      end
      MODE_INC: r = reduce_fraction(sm_add(an, ad), ad);
      default: r = reduce_fraction(sm_add(an, sm_neg(ad)), ad);
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0001;
      4: return $urandom;
      5: return {$urandom} >> $urandom_range(0, 31);
      default: return $urandom_range(0, 400) - 200;
    endcase
  endfunction

  // mostly nonzero denominators so that most requests get past the error check
  function automatic logic [31:0] pick_den();
    logic [31:0] v;
    v = pick_value();
    if (v == 0 && $urandom_range(0, 7) != 0) v = 32'd1;
    return v;
  endfunction

  task automatic push_req(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    request_t q;
    q.mode = m;
    q.a_num = an;
    q.a_den = ad;
    q.b_num = bn;
    q.b_den = bd;
    pending_q.push_back(q);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
    mismatches++;
  endtask

  // ---------------- driver ----------------
  // inputs change at the falling edge; valid holds until accepted
  logic     accepted;
  request_t cur_req;

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (!req.valid || accepted) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = pending_q.pop_front();
          req.valid <= 1'b1;
          req.mode <= cur_req.mode;
          req.a_num <= cur_req.a_num;
          req.a_den <= cur_req.a_den;
          req.b_num <= cur_req.b_num;
          req.b_den <= cur_req.b_den;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    answer_t want;
    request_t q;
    if (rst) begin
      accepted <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      accepted <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        q.mode = req.mode;
        q.a_num = req.a_num;
        q.a_den = req.a_den;
        q.b_num = req.b_num;
        q.b_den = req.b_den;
        answer_q.push_back(rational_result(q));
      end
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected response", rsp.res_num, 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (rsp.res_num !== want.res_num)
            report_mismatch("res_num", rsp.res_num, want.res_num);
          if (rsp.res_den !== want.res_den)
            report_mismatch("res_den", {1'b0, rsp.res_den}, {1'b0, want.res_den});
          if (rsp.is_less !== want.is_less)
            report_mismatch("is_less", {31'd0, rsp.is_less}, {31'd0, want.is_less});
          if (rsp.is_equal !== want.is_equal)
            report_mismatch("is_equal", {31'd0, rsp.is_equal}, {31'd0, want.is_equal});
          if (rsp.div_error !== want.div_error)
            report_mismatch("div_error", {31'd0, rsp.div_error}, {31'd0, want.div_error});
          if (rsp.overflow !== want.overflow)
            report_mismatch("overflow", {31'd0, rsp.overflow}, {31'd0, want.overflow});
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int unsigned m;
    req.valid = 1'b0;
    req.mode = '0;
    req.a_num = '0;
    req.a_den = '0;
    req.b_num = '0;
    req.b_den = '0;
    rsp.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 65;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every mode, extremes, zero denominators, overflow
    push_req(MODE_REDUCE, 32'd6, 32'hFFFF_FFFC, 0, 1);           // sign moves up
    push_req(MODE_REDUCE, 32'd0, 32'h8000_0000, 0, 1);           // zero numerator
    push_req(MODE_REDUCE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);   // 2^31 overflows
    push_req(MODE_REDUCE, 32'd5, 32'd0, 0, 1);                   // zero denominator
    push_req(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    push_req(MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    push_req(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    push_req(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    push_req(MODE_SUB, 32'h8000_0001, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_req(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'd3, 32'd7);
    push_req(MODE_MUL, 32'h7FFF_FFFF, 32'd2, 32'h7FFF_FFFF, 32'd3);
    push_req(MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd5);              // divide by zero
    push_req(MODE_DIV, 32'hFFFF_FFFD, 32'd4, 32'd9, 32'hFFFF_FFF8);
    push_req(MODE_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
    push_req(MODE_CMP, 32'd2, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'd2);
    push_req(MODE_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
    push_req(MODE_CMP, 32'd1, 32'd0, 32'd1, 32'd1);
    push_req(MODE_INC, 32'hFFFF_FFFF, 32'd1, 0, 0);              // B ignored
    push_req(MODE_INC, 32'h7FFF_FFFF, 32'd1, 0, 0);
    push_req(MODE_DEC, 32'h8000_0001, 32'd1, 0, 0);
    push_req(MODE_DEC, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(MODE_DEC, 32'd1, 32'd0, 0, 1);

    for (int i = 0; i < NUM_RAND; i++) begin
      m = $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0)
        push_req(m, $urandom, $urandom, $urandom, $urandom);
      else
        push_req(m, pick_value(), pick_den(), pick_value(), pick_den());
      if (i == NUM_RAND / 3) begin
        wait (pending_q.size() == 0);
        send_idle_pct = 65;
        recv_idle_pct = 26;
      end
      if (i == 2 * NUM_RAND / 3) begin
        wait (pending_q.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (pending_q.size() == 0 && !req.valid && answer_q.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("PASS rational_arithmetic_unit");
    end else begin
      $display("FAIL rational_arithmetic_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_if.sv
hw/rtl/rau_front.sv
hw/rtl/rau_queue.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
